/* design/htki_pkg.sv */
// Shared types and constants for the hashed tree key index.
// Used by every module of the block but htki_ram; no dependencies.
package htki_pkg;

    localparam int BUCKETS = 1024;
    localparam int NODES   = 1024;
    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int NODE_W  = $clog2(NODES);
    localparam int PTR_W   = NODE_W + 1;
    localparam int CLR_LEN = (BUCKETS > NODES) ? BUCKETS : NODES;
    localparam int CLR_W   = $clog2(CLR_LEN);
    localparam int VAL_W   = 31 + 32 + 48;

    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(NODES);

    localparam logic [1:0] MODE_SEARCH = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_POOL_FULL = 2'd3;

    localparam logic [31:0] HASH_A_INIT = 32'd5381;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  key_byte;
        logic        key_last;
        logic [30:0] value_length;
        logic [31:0] buffer_ref;
        logic [47:0] disk_position;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [9:0]         node_index;
        logic signed [31:0] found_length;
        logic [31:0]        found_buffer;
        logic [47:0]        found_position;
    } out_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } hash_t;

endpackage

/* design/htki_ram.sv */
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module htki_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* design/htki_hash.sv */
// Key hashes: times-33, ELF, alternating shift-xor; one byte a cycle on enable.
// Depends on htki_pkg.
module htki_hash (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  last,
    input  logic [7:0]            key_byte,
    output htki_pkg::hash_t       hash_next
);
    import htki_pkg::*;

    hash_t hash_reg;
    logic  parity_reg;
    logic [31:0] byte_w, b_t, x;

    always_comb begin
        byte_w = {24'd0, key_byte};
        hash_next.a = (hash_reg.a << 5) + hash_reg.a + byte_w;
        b_t = (hash_reg.b << 4) + byte_w;
        x   = b_t & 32'hF000_0000;
        hash_next.b = (x != 32'd0) ? ((b_t ^ (x >> 24)) & ~x) : b_t;
        if (!parity_reg) begin
            hash_next.c = hash_reg.c ^ (hash_reg.c << 7) ^ byte_w ^ (hash_reg.c >> 3);
        end else begin
            hash_next.c = hash_reg.c ^ ~((hash_reg.c << 11) ^ byte_w ^ (hash_reg.c >> 5));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg   <= '{a: HASH_A_INIT, b: 32'd0, c: 32'd0};
            parity_reg <= 1'b0;
        end else if (en) begin
            if (last) begin
                hash_reg   <= '{a: HASH_A_INIT, b: 32'd0, c: 32'd0};
                parity_reg <= 1'b0;
            end else begin
                hash_reg   <= hash_next;
                parity_reg <= ~parity_reg;
            end
        end
    end
endmodule

/* design/htki_engine.sv */
// Tree sequencer: bucket heads, node pool and free stack in synchronous RAMs,
// walked and relinked by read-modify-write steps. Depends on htki_pkg, htki_ram.
module htki_engine (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  htki_pkg::hash_t       hash_in,
    input  htki_pkg::in_t         item,
    output logic                  idle,
    output logic                  m_valid,
    input  logic                  m_ready,
    output htki_pkg::out_t        m_data
);
    import htki_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0,  S_HEAD = 4'd1,  S_FETCH = 4'd2,
                           S_CMP = 4'd3,   S_POP = 4'd4,   S_INS_L = 4'd5,
                           S_DEL = 4'd6,   S_SFETCH = 4'd7, S_SCMP = 4'd8,
                           S_DW1 = 4'd9,   S_DW2 = 4'd10,  S_DW3 = 4'd11,
                           S_VAL = 4'd12,  S_RES = 4'd13;

    localparam logic [1:0] K_HEAD = 2'd0, K_LEFT = 2'd1, K_RIGHT = 2'd2;
    localparam logic [1:0] SRC_NONE = 2'd0, SRC_RAM = 2'd1, SRC_IN = 2'd2;

    logic [3:0]        state_reg, state_next;
    logic              clr_reg, clr_next;
    logic [CLR_W-1:0]  clr_idx_reg, clr_idx_next;
    logic [1:0]        mode_reg, mode_next;
    logic [31:0]       keyb_reg, keyb_next, keyc_reg, keyc_next;
    logic [BKT_W-1:0]  bkt_reg, bkt_next;
    logic [VAL_W-1:0]  vals_reg, vals_next;
    logic [PTR_W-1:0]  cur_reg, cur_next, succ_reg, succ_next;
    logic [PTR_W-1:0]  dl_reg, dl_next, dr_reg, dr_next, srr_reg, srr_next;
    logic [1:0]        slot_kind_reg, slot_kind_next, sp_kind_reg, sp_kind_next;
    logic [NODE_W-1:0] slot_node_reg, slot_node_next, sp_node_reg, sp_node_next;
    logic [PTR_W-1:0]  steps_reg, steps_next, free_cnt_reg, free_cnt_next;
    logic [1:0]        res_st_reg, res_st_next, res_src_reg, res_src_next;
    logic [NODE_W-1:0] res_node_reg, res_node_next;
    logic              m_valid_reg, m_valid_next;
    out_t              m_data_reg, m_data_next;

    // RAM ports
    logic              hd_we, pr_we, ll_we, rl_we, vl_we, fs_we;
    logic [BKT_W-1:0]  hd_waddr;
    logic [PTR_W-1:0]  hd_wdata, hd_rdata, ll_wdata, ll_rdata, rl_wdata, rl_rdata;
    logic [NODE_W-1:0] ll_waddr, rl_waddr, fs_waddr, fs_wdata, fs_rdata;
    logic [NODE_W-1:0] pr_waddr, vl_waddr, lk_raddr, fs_raddr;
    logic [63:0]       pr_rdata;
    logic [VAL_W-1:0]  vl_rdata;

    // Generic link write: slot or successor parent
    logic              lw_en;
    logic [1:0]        lw_kind;
    logic [NODE_W-1:0] lw_node;
    logic [PTR_W-1:0]  lw_val;
    logic [PTR_W-1:0]  cnt_m1;

    htki_ram #(.DEPTH(BUCKETS), .WIDTH(PTR_W)) u_heads (
        .aclk, .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
        .raddr(hash_in.a[BKT_W-1:0]), .rdata(hd_rdata));
    htki_ram #(.DEPTH(NODES), .WIDTH(64)) u_pair (
        .aclk, .we(pr_we), .waddr(pr_waddr), .wdata({keyb_reg, keyc_reg}),
        .raddr(cur_reg[NODE_W-1:0]), .rdata(pr_rdata));
    htki_ram #(.DEPTH(NODES), .WIDTH(PTR_W)) u_left (
        .aclk, .we(ll_we), .waddr(ll_waddr), .wdata(ll_wdata),
        .raddr(lk_raddr), .rdata(ll_rdata));
    htki_ram #(.DEPTH(NODES), .WIDTH(PTR_W)) u_right (
        .aclk, .we(rl_we), .waddr(rl_waddr), .wdata(rl_wdata),
        .raddr(lk_raddr), .rdata(rl_rdata));
    htki_ram #(.DEPTH(NODES), .WIDTH(VAL_W)) u_vals (
        .aclk, .we(vl_we), .waddr(vl_waddr), .wdata(vals_reg),
        .raddr(res_node_reg), .rdata(vl_rdata));
    htki_ram #(.DEPTH(NODES), .WIDTH(NODE_W)) u_free (
        .aclk, .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
        .raddr(fs_raddr), .rdata(fs_rdata));

    assign cnt_m1   = free_cnt_reg - PTR_W'(1);
    assign fs_raddr = cnt_m1[NODE_W-1:0];
    assign lk_raddr = (state_reg == S_SFETCH) ? succ_reg[NODE_W-1:0]
                                              : cur_reg[NODE_W-1:0];
    assign pr_waddr = fs_rdata;
    assign vl_waddr = fs_rdata;
    assign idle     = (state_reg == S_IDLE) && !clr_reg;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Link writes by state
    always_comb begin
        lw_en   = 1'b0;
        lw_kind = slot_kind_reg;
        lw_node = slot_node_reg;
        lw_val  = NULL_PTR;
        case (state_reg)
            S_INS_L: begin
                lw_en  = 1'b1;
                lw_val = {1'b0, res_node_reg};
            end
            S_DEL: begin
                lw_en  = !(!dl_reg[NODE_W] && !dr_reg[NODE_W]);
                lw_val = dl_reg[NODE_W] ? dr_reg : dl_reg;
            end
            S_DW1: begin
                lw_en   = 1'b1;
                lw_kind = sp_kind_reg;
                lw_node = sp_node_reg;
                lw_val  = srr_reg;
            end
            S_DW3: begin
                lw_en  = 1'b1;
                lw_val = succ_reg;
            end
            default: ;
        endcase
    end

    always_comb begin
        hd_we    = clr_reg || (lw_en && lw_kind == K_HEAD);
        hd_waddr = clr_reg ? clr_idx_reg[BKT_W-1:0] : bkt_reg;
        hd_wdata = clr_reg ? NULL_PTR : lw_val;
        fs_we    = clr_reg && ({1'b0, clr_idx_reg} < (CLR_W + 1)'(NODES));
        fs_waddr = clr_idx_reg[NODE_W-1:0];
        fs_wdata = clr_idx_reg[NODE_W-1:0];
        if (state_reg == S_DEL && free_cnt_reg < PTR_W'(NODES)) begin
            fs_we    = 1'b1;
            fs_waddr = free_cnt_reg[NODE_W-1:0];
            fs_wdata = cur_reg[NODE_W-1:0];
        end
        pr_we    = (state_reg == S_POP);
        vl_we    = (state_reg == S_POP);
        ll_we    = 1'b0;
        ll_waddr = lw_node;
        ll_wdata = lw_val;
        rl_we    = 1'b0;
        rl_waddr = lw_node;
        rl_wdata = lw_val;
        case (state_reg)
            S_POP: begin
                ll_we    = 1'b1;
                ll_waddr = fs_rdata;
                ll_wdata = NULL_PTR;
                rl_we    = 1'b1;
                rl_waddr = fs_rdata;
                rl_wdata = NULL_PTR;
            end
            S_DW2: begin
                ll_we    = 1'b1;
                ll_waddr = succ_reg[NODE_W-1:0];
                ll_wdata = dl_reg;
                rl_we    = 1'b1;
                rl_waddr = succ_reg[NODE_W-1:0];
                // successor directly right of the victim keeps its own right child
                rl_wdata = (sp_kind_reg == K_RIGHT && sp_node_reg == cur_reg[NODE_W-1:0])
                           ? srr_reg : dr_reg;
            end
            default: begin
                ll_we = lw_en && lw_kind == K_LEFT;
                rl_we = lw_en && lw_kind == K_RIGHT;
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        clr_idx_next   = clr_idx_reg;
        mode_next      = mode_reg;
        keyb_next      = keyb_reg;
        keyc_next      = keyc_reg;
        bkt_next       = bkt_reg;
        vals_next      = vals_reg;
        cur_next       = cur_reg;
        succ_next      = succ_reg;
        dl_next        = dl_reg;
        dr_next        = dr_reg;
        srr_next       = srr_reg;
        slot_kind_next = slot_kind_reg;
        slot_node_next = slot_node_reg;
        sp_kind_next   = sp_kind_reg;
        sp_node_next   = sp_node_reg;
        steps_next     = steps_reg;
        free_cnt_next  = free_cnt_reg;
        res_st_next    = res_st_reg;
        res_src_next   = res_src_reg;
        res_node_next  = res_node_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (clr_reg) begin
            clr_idx_next = clr_idx_reg + CLR_W'(1);
            if (clr_idx_reg == CLR_W'(CLR_LEN - 1)) begin
                clr_next = 1'b0;
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    mode_next  = item.mode;
                    keyb_next  = hash_in.b;
                    keyc_next  = hash_in.c;
                    bkt_next   = hash_in.a[BKT_W-1:0];
                    vals_next  = {item.value_length, item.buffer_ref, item.disk_position};
                    state_next = S_HEAD;
                end
            end
            S_HEAD: begin
                cur_next       = hd_rdata;
                slot_kind_next = K_HEAD;
                steps_next     = '0;
                state_next     = S_FETCH;
            end
            S_FETCH: begin
                if (cur_reg[NODE_W] || steps_reg == PTR_W'(NODES)) begin
                    res_node_next = '0;
                    res_src_next  = SRC_NONE;
                    state_next    = S_RES;
                    if (mode_reg == MODE_INSERT) begin
                        if (free_cnt_reg == '0) begin
                            res_st_next = ST_POOL_FULL;
                        end else begin
                            state_next = S_POP;
                        end
                    end else begin
                        res_st_next = ST_NOT_FOUND;
                    end
                end else begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                dl_next = ll_rdata;
                dr_next = rl_rdata;
                if ({keyb_reg, keyc_reg} == pr_rdata) begin
                    res_node_next = cur_reg[NODE_W-1:0];
                    case (mode_reg)
                        MODE_INSERT: begin
                            res_st_next  = ST_DUPLICATE;
                            res_src_next = SRC_NONE;
                            state_next   = S_RES;
                        end
                        MODE_DELETE: begin
                            res_st_next  = ST_OK;
                            res_src_next = SRC_RAM;
                            state_next   = S_DEL;
                        end
                        default: begin
                            res_st_next  = ST_OK;
                            res_src_next = SRC_RAM;
                            state_next   = S_VAL;
                        end
                    endcase
                end else begin
                    slot_node_next = cur_reg[NODE_W-1:0];
                    if ({keyb_reg, keyc_reg} < pr_rdata) begin
                        slot_kind_next = K_LEFT;
                        cur_next       = ll_rdata;
                    end else begin
                        slot_kind_next = K_RIGHT;
                        cur_next       = rl_rdata;
                    end
                    steps_next = steps_reg + PTR_W'(1);
                    state_next = S_FETCH;
                end
            end
            S_POP: begin
                free_cnt_next = cnt_m1;
                res_node_next = fs_rdata;
                res_st_next   = ST_OK;
                res_src_next  = SRC_IN;
                state_next    = S_INS_L;
            end
            S_INS_L: begin
                state_next = S_RES;
            end
            S_DEL: begin
                if (free_cnt_reg < PTR_W'(NODES)) begin
                    free_cnt_next = free_cnt_reg + PTR_W'(1);
                end
                if (!dl_reg[NODE_W] && !dr_reg[NODE_W]) begin
                    succ_next    = dr_reg;
                    sp_kind_next = K_RIGHT;
                    sp_node_next = cur_reg[NODE_W-1:0];
                    steps_next   = '0;
                    state_next   = S_SFETCH;
                end else begin
                    state_next = S_VAL;
                end
            end
            S_SFETCH: begin
                state_next = S_SCMP;
            end
            S_SCMP: begin
                if (ll_rdata[NODE_W] || steps_reg == PTR_W'(NODES)) begin
                    srr_next   = rl_rdata;
                    state_next = S_DW1;
                end else begin
                    sp_kind_next = K_LEFT;
                    sp_node_next = succ_reg[NODE_W-1:0];
                    succ_next    = ll_rdata;
                    steps_next   = steps_reg + PTR_W'(1);
                    state_next   = S_SFETCH;
                end
            end
            S_DW1: state_next = S_DW2;
            S_DW2: state_next = S_DW3;
            S_DW3: state_next = S_VAL;
            S_VAL: state_next = S_RES;
            S_RES: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.status      = res_st_reg;
                    m_data_next.node_index  = (res_src_reg != SRC_NONE ||
                                               res_st_reg == ST_DUPLICATE)
                                              ? res_node_reg : '0;
                    case (res_src_reg)
                        SRC_RAM: begin
                            m_data_next.found_length   = {1'b0, vl_rdata[110:80]};
                            m_data_next.found_buffer   = vl_rdata[79:48];
                            m_data_next.found_position = vl_rdata[47:0];
                        end
                        SRC_IN: begin
                            m_data_next.found_length   = {1'b0, vals_reg[110:80]};
                            m_data_next.found_buffer   = vals_reg[79:48];
                            m_data_next.found_position = vals_reg[47:0];
                        end
                        default: begin
                            m_data_next.found_length   = -32'sd1;
                            m_data_next.found_buffer   = '0;
                            m_data_next.found_position = '0;
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            clr_reg      <= 1'b1;
            clr_idx_reg  <= '0;
            free_cnt_reg <= PTR_W'(NODES);
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            clr_idx_reg  <= clr_idx_next;
            free_cnt_reg <= free_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
        mode_reg      <= mode_next;
        keyb_reg      <= keyb_next;
        keyc_reg      <= keyc_next;
        bkt_reg       <= bkt_next;
        vals_reg      <= vals_next;
        cur_reg       <= cur_next;
        succ_reg      <= succ_next;
        dl_reg        <= dl_next;
        dr_reg        <= dr_next;
        srr_reg       <= srr_next;
        slot_kind_reg <= slot_kind_next;
        slot_node_reg <= slot_node_next;
        sp_kind_reg   <= sp_kind_next;
        sp_node_reg   <= sp_node_next;
        steps_reg     <= steps_next;
        res_st_reg    <= res_st_next;
        res_src_reg   <= res_src_next;
        res_node_reg  <= res_node_next;
        m_data_reg    <= m_data_next;
    end
endmodule

/* design/hashed_tree_key_index.sv */
// Hashed tree key index. A key byte that is not the last only updates the hashes.
// The last byte starts a tree walk. Insert adds the pop and link steps, delete the
// free step, and a two-child delete also walks to the in-order successor and
// relinks it. Input ready returns once the result is registered on the output.
// After reset a clearing pass empties the bucket heads and fills the free stack;
// no transfer is taken until it ends.
module hashed_tree_key_index (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  htki_pkg::in_t    s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output htki_pkg::out_t   m_data
);
    import htki_pkg::*;

    logic  accept, idle;
    hash_t hash_next;

    assign s_ready = idle;
    assign accept  = s_valid && s_ready;

    htki_hash u_hash (
        .aclk, .aresetn, .en(accept), .last(s_data.key_last),
        .key_byte(s_data.key_byte), .hash_next);

    htki_engine u_engine (
        .aclk, .aresetn, .start(accept && s_data.key_last), .hash_in(hash_next),
        .item(s_data), .idle, .m_valid, .m_ready, .m_data);
endmodule

/* design/htki_checker.sv */
// Port-level checks for the hashed tree key index, bound to the top level.
// Depends on htki_pkg.
module htki_props (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input htki_pkg::in_t    s_data,
    input logic             m_valid,
    input logic             m_ready,
    input htki_pkg::out_t   m_data
);
    import htki_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_miss_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |->
        m_data.found_length == -32'sd1 && m_data.found_buffer == '0 &&
        m_data.found_position == '0)
        else $error("value fields set on a failed operation");

    a_full_node: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_POOL_FULL || m_data.status == ST_NOT_FOUND) |->
        m_data.node_index == '0)
        else $error("node index set without a node");

    a_ok_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_OK |-> !m_data.found_length[31])
        else $error("negative length on a hit");
endmodule

bind hashed_tree_key_index htki_props u_checker (.*);

/* tb/htki_checker.sv */
// Watches both channels of the hashed tree key index, keeps its own copy of
// the hashes, trees and free stack, and compares every result. Depends on htki_pkg.
`timescale 1ns / 1ps
module htki_checker
    import htki_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_ready,
    input  in_t  s_data,
    input  logic m_valid,
    input  logic m_ready,
    input  out_t m_data,
    output int   errors,
    output int   pending
);

    typedef logic [PTR_W-1:0] ptr_t;
    typedef enum int {LINK_HEAD, LINK_LEFT, LINK_RIGHT} link_kind_e;

    ptr_t              heads [BUCKETS];
    logic [31:0]       pair_b [NODES];
    logic [31:0]       pair_c [NODES];
    ptr_t              left_of [NODES];
    ptr_t              right_of [NODES];
    logic [30:0]       len_of [NODES];
    logic [31:0]       buf_of [NODES];
    logic [47:0]       pos_of [NODES];
    logic [NODE_W-1:0] free_list [NODES];
    int                free_top;
    logic [31:0]       hash_a, hash_b, hash_c;
    logic              odd_byte;
    out_t              result_q[$];

    assign pending = result_q.size();

    function automatic ptr_t read_link(link_kind_e kind, int idx);
        case (kind)
            LINK_HEAD: read_link = heads[idx];
            LINK_LEFT: read_link = left_of[idx];
            default:   read_link = right_of[idx];
        endcase
    endfunction

    function automatic void write_link(link_kind_e kind, int idx, ptr_t v);
        case (kind)
            LINK_HEAD: heads[idx] = v;
            LINK_LEFT: left_of[idx] = v;
            default:   right_of[idx] = v;
        endcase
    endfunction

    function automatic out_t report(logic [1:0] st, int node, bit with_vals);
        out_t r;
        r.status = st;
        if (with_vals && node < NODES) begin
            r.node_index     = node[9:0];
            r.found_length   = {1'b0, len_of[node]};
            r.found_buffer   = buf_of[node];
            r.found_position = pos_of[node];
        end else begin
            r.node_index     = (st == ST_DUPLICATE) ? node[9:0] : 10'd0;
            r.found_length   = -32'sd1;
            r.found_buffer   = '0;
            r.found_position = '0;
        end
        return r;
    endfunction

    // Apply one accepted key byte; queue a result on the last byte.
    function automatic void apply_byte(in_t d);
        logic [31:0] b, x;
        int bucket, node, steps, idx, l, r, s, sp_idx;
        link_kind_e kind, sp_kind;
        ptr_t cur;
        out_t res;
        b = {24'd0, d.key_byte};
        hash_a = hash_a * 32'd33 + b;
        hash_b = (hash_b << 4) + b;
        x = hash_b & 32'hF000_0000;
        if (x != 0) begin
            hash_b ^= x >> 24;
            hash_b &= ~x;
        end
        if (!odd_byte) hash_c ^= (hash_c << 7) ^ b ^ (hash_c >> 3);
        else hash_c ^= ~((hash_c << 11) ^ b ^ (hash_c >> 5));
        odd_byte = ~odd_byte;
        if (!d.key_last) return;

        bucket = (hash_a & 32'h7FFF_FFFF) % BUCKETS;
        kind = LINK_HEAD;
        idx = bucket;
        node = NODES;
        steps = 0;
        cur = read_link(kind, idx);
        while (cur < NODES && steps < NODES) begin
            if (hash_b == pair_b[cur] && hash_c == pair_c[cur]) begin
                node = cur;
                break;
            end
            kind = ({hash_b, hash_c} < {pair_b[cur], pair_c[cur]}) ? LINK_LEFT : LINK_RIGHT;
            idx = cur;
            cur = read_link(kind, idx);
            steps++;
        end

        if (d.mode == MODE_INSERT) begin
            if (node < NODES) res = report(ST_DUPLICATE, node, 0);
            else if (free_top < 0) res = report(ST_POOL_FULL, 0, 0);
            else begin
                node = free_list[free_top];
                free_top--;
                pair_b[node] = hash_b;
                pair_c[node] = hash_c;
                left_of[node] = NULL_PTR;
                right_of[node] = NULL_PTR;
                len_of[node] = d.value_length;
                buf_of[node] = d.buffer_ref;
                pos_of[node] = d.disk_position;
                write_link(kind, idx, ptr_t'(node));
                res = report(ST_OK, node, 1);
            end
        end else if (d.mode == MODE_DELETE) begin
            if (node >= NODES) res = report(ST_NOT_FOUND, 0, 0);
            else begin
                l = left_of[node];
                r = right_of[node];
                if (l >= NODES && r >= NODES) write_link(kind, idx, NULL_PTR);
                else if (l < NODES && r < NODES) begin
                    // splice out the in-order successor and move it up
                    sp_kind = LINK_RIGHT;
                    sp_idx = node;
                    s = r;
                    steps = 0;
                    while (left_of[s] < NODES && steps < NODES) begin
                        sp_kind = LINK_LEFT;
                        sp_idx = s;
                        s = left_of[s];
                        steps++;
                    end
                    write_link(sp_kind, sp_idx, right_of[s]);
                    left_of[s] = left_of[node];
                    right_of[s] = right_of[node];
                    write_link(kind, idx, ptr_t'(s));
                end else write_link(kind, idx, ptr_t'((l >= NODES) ? r : l));
                if (free_top < NODES - 1) begin
                    free_top++;
                    free_list[free_top] = node[NODE_W-1:0];
                end
                res = report(ST_OK, node, 1);
            end
        end else begin
            res = (node < NODES) ? report(ST_OK, node, 1) : report(ST_NOT_FOUND, 0, 0);
        end
        result_q.push_back(res);
        hash_a = HASH_A_INIT;
        hash_b = '0;
        hash_c = '0;
        odd_byte = 1'b0;
    endfunction

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            for (int i = 0; i < BUCKETS; i++) heads[i] = NULL_PTR;
            for (int i = 0; i < NODES; i++) free_list[i] = i[NODE_W-1:0];
            free_top = NODES - 1;
            hash_a = HASH_A_INIT;
            hash_b = '0;
            hash_c = '0;
            odd_byte = 1'b0;
            result_q.delete();
            errors = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result %p", m_data);
                end else begin
                    want = result_q.pop_front();
                    if (m_data.status !== want.status
                        || m_data.node_index !== want.node_index
                        || m_data.found_length !== want.found_length
                        || m_data.found_buffer !== want.found_buffer
                        || m_data.found_position !== want.found_position) begin
                        errors++;
                        if (errors <= 10)
                            $display("result differs: expected %p, got %p", want, m_data);
                    end
                end
            end
            if (s_valid && s_ready) apply_byte(s_data);
        end
    end

endmodule

/* tb/testbench.sv */
// Stimulus and verdict for the hashed tree key index: drives key bytes and the
// result ready, instantiates the block and htki_checker. Depends on htki_pkg.
`timescale 1ns / 1ps
module testbench;
    import htki_pkg::*;

    typedef struct {
        int         n;
        logic [7:0] kb [3];
    } key_t;

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready;
    in_t  s_data;
    out_t m_data;
    int   errors, pending;
    bit   calm, hold_go, hold_done;
    key_t known[$];

    hashed_tree_key_index dut (.*);

    htki_checker u_checker (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .errors(errors), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #200ms;
        $display("hashed_tree_key_index: mismatch");
        $finish;
    end

    // Result side: random stalls, one long hold-off while keys keep coming.
    initial begin
        m_ready = 1'b0;
        forever begin
            if (hold_go && !hold_done) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_done = 1;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 9);
                @(posedge aclk);
            end
        end
    end

    task automatic send_byte(in_t d);
        if (!calm && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic run_op(logic [1:0] mode, key_t k, logic [30:0] len = 31'($urandom),
                          logic [31:0] bref = $urandom,
                          logic [47:0] pos = 48'({$urandom, $urandom}));
        in_t d;
        for (int i = 0; i < k.n; i++) begin
            d.mode          = (i == k.n - 1) ? mode : 2'($urandom);
            d.key_byte      = k.kb[i];
            d.key_last      = (i == k.n - 1);
            d.value_length  = (i == k.n - 1) ? len : 31'($urandom);
            d.buffer_ref    = (i == k.n - 1) ? bref : $urandom;
            d.disk_position = (i == k.n - 1) ? pos : 48'({$urandom, $urandom});
            send_byte(d);
        end
        if (mode == MODE_INSERT) known.push_back(k);
    endtask

    function automatic key_t any_key(int nmax);
        key_t k;
        k.n = $urandom_range(1, nmax);
        foreach (k.kb[i]) k.kb[i] = 8'($urandom);
        return k;
    endfunction

    // Two-byte keys whose times-33 hash lands in one of a few buckets, so trees grow deep.
    function automatic key_t crowded_key();
        key_t k;
        int target, lo;
        target = 250 + 300 * $urandom_range(2);
        k.n = 2;
        k.kb[2] = 0;
        do begin
            k.kb[0] = 8'($urandom);
            lo = (target - 33 * k.kb[0]) & 1023;
        end while (lo > 255);
        k.kb[1] = lo[7:0];
        return k;
    endfunction

    function automatic key_t old_key();
        if (known.size() == 0) return any_key(3);
        return known[$urandom_range(known.size() - 1)];
    endfunction

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        key_t k;
        int roll, fill;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        calm = 1;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every mode, duplicates, misses
        k = '{n: 1, kb: '{8'h00, 8'h00, 8'h00}};
        run_op(MODE_INSERT, k, '1, '1, '1);
        run_op(MODE_INSERT, k, '0, '0, '0);
        run_op(MODE_SEARCH, k);
        k.kb[0] = 8'hFF;
        run_op(MODE_SEARCH, k);
        run_op(MODE_DELETE, k);
        run_op(MODE_INSERT, k, '0, '0, '0);
        run_op(2'd3, k);
        run_op(MODE_DELETE, k);
        run_op(MODE_SEARCH, k);
        for (int i = 0; i < 6; i++) run_op(MODE_INSERT, crowded_key());
        run_op(MODE_DELETE, known[1]);
        run_op(MODE_DELETE, known[2]);

        // random: operations in every mode, mostly on known keys or crowded buckets
        for (int item = 0; item < 400; item++) begin
            calm = (item >= 150 && item < 230);
            if (item == 300) hold_go = 1;
            roll = $urandom_range(99);
            if (roll < 35) run_op(MODE_INSERT, ($urandom_range(1)) ? crowded_key() : any_key(3));
            else if (roll < 60) run_op(MODE_SEARCH, old_key());
            else if (roll < 85) run_op(MODE_DELETE, old_key());
            else if (roll < 92) run_op(2'($urandom), any_key(3));
            else run_op(MODE_INSERT, old_key());
        end

        // pause until every result is back, then a burst of short-key inserts and delete, search, insert rounds
        calm = 0;
        wait_drained();
        for (fill = 0; fill < 150; fill++) run_op(MODE_INSERT, any_key(2));
        for (int i = 0; i < 40; i++) begin
            k = old_key();
            run_op(MODE_DELETE, k);
            run_op(MODE_SEARCH, k);
            run_op(MODE_INSERT, crowded_key());
        end

        s_valid <= 1'b0;
        fill = 0;
        while (pending != 0 && fill < 200000) begin
            @(posedge aclk);
            fill++;
        end
        if (pending != 0) begin
            $display("hashed_tree_key_index: mismatch");
            $finish;
        end
        repeat (60) @(posedge aclk);
        if (errors == 0 && pending == 0) $display("hashed_tree_key_index: match");
        else $display("hashed_tree_key_index: mismatch");
        $finish;
    end

endmodule
